@@ hdl/kama_pkg.sv @@
// ----------------------------------------------------------------------------
// KAMA package
// Shared types and constants for the adaptive moving average core.
// ----------------------------------------------------------------------------
`default_nettype none

package kama_pkg;

  localparam int unsigned SampleBits  = 16;
  localparam int unsigned MaxWindow   = 128;
  localparam int unsigned RingAw      = $clog2(MaxWindow);
  localparam int unsigned CountBits   = RingAw + 1;
  localparam int unsigned DiffBits    = SampleBits;
  localparam int unsigned VolBits     = DiffBits + RingAw + 1;
  localparam int unsigned FracBits    = 16;
  localparam int unsigned QBits       = FracBits + 1;
  localparam int unsigned AvgBits     = SampleBits + FracBits + 1;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 17;
  localparam int unsigned WinRegBits  = 8;

  localparam logic [WinRegBits-1:0]  WindowReset = WinRegBits'(10);
  localparam logic [CfgDataBits-1:0] FastReset   = CfgDataBits'(43691);
  localparam logic [CfgDataBits-1:0] SlowReset   = CfgDataBits'(4228);
  localparam logic [QBits-1:0]       QOne        = QBits'(1) << FracBits;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [DiffBits-1:0]          diff_t;
  typedef logic [VolBits-1:0]           vol_t;
  typedef logic [QBits-1:0]             q_t;
  typedef logic signed [AvgBits-1:0]    avg_t;
  typedef logic [RingAw-1:0]            ring_addr_t;

  typedef struct packed {
    sample_t smp_re;
    sample_t smp_im;
    diff_t   dif_re;
    diff_t   dif_im;
  } ring_word_t;

  typedef enum logic [CfgIdxBits-1:0] {
    RegWindow = 2'd0,
    RegFast   = 2'd1,
    RegSlow   = 2'd2
  } cfg_reg_e;

endpackage

`default_nettype wire

@@ hdl/kama_ring_ram.sv @@
// ----------------------------------------------------------------------------
// KAMA ring memory
// Simple dual-port memory holding the sample and difference history.
// ----------------------------------------------------------------------------
`default_nettype none

module kama_ring_ram (
  input  wire                  clk_i,
  input  wire                  wr_en_i,
  input  kama_pkg::ring_addr_t wr_addr_i,
  input  kama_pkg::ring_word_t wr_data_i,
  input  kama_pkg::ring_addr_t rd_addr_i,
  output kama_pkg::ring_word_t rd_data_o
);
  import kama_pkg::*;

  ring_word_t mem [MaxWindow];
  ring_word_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

@@ hdl/kama_div.sv @@
// ----------------------------------------------------------------------------
// KAMA ratio divider
// Restoring divider giving the Q1.16 efficiency ratio, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kama_div (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             start_i,
  input  kama_pkg::diff_t dividend_i,
  input  kama_pkg::vol_t  divisor_i,
  output logic            done_o,
  output kama_pkg::q_t    quot_o
);
  import kama_pkg::*;

  localparam int unsigned CntBits = $clog2(FracBits);

  logic                busy_q;
  logic                done_q;
  logic [CntBits-1:0]  cnt_q;
  vol_t                rem_q;
  vol_t                divisor_q;
  logic [FracBits-1:0] quo_q;
  q_t                  result_q;

  logic [VolBits:0]    rem_shift;
  logic                take;
  vol_t                rem_d;
  logic [FracBits-1:0] quo_d;

  always_comb begin
    rem_shift = {rem_q, 1'b0};
    take      = rem_shift >= {1'b0, divisor_q};
    rem_d     = take ? VolBits'(rem_shift - {1'b0, divisor_q}) : VolBits'(rem_shift);
    quo_d     = {quo_q[FracBits-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        // A ratio of one or more saturates, so only the fractional bits are divided out.
        if (divisor_i == '0) begin
          done_q <= 1'b1;
        end else if (VolBits'(dividend_i) >= divisor_i) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntBits'(FracBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
      rem_q     <= VolBits'(dividend_i);
      quo_q     <= '0;
      if (divisor_i == '0) begin
        result_q <= '0;
      end else if (VolBits'(dividend_i) >= divisor_i) begin
        result_q <= QOne;
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
      if (cnt_q == CntBits'(FracBits - 1)) begin
        result_q <= {1'b0, quo_d};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = result_q;

endmodule

`default_nettype wire

@@ hdl/kaufman_adaptive_moving_average_core.sv @@
// ----------------------------------------------------------------------------
// Kaufman adaptive moving average core
// Filters I and Q separately with an efficiency-ratio driven average.
// ----------------------------------------------------------------------------
// Processing: once the window is full, two 16-step ratio divisions run on the one shared
//   divider, one per component, each followed by the multiplies; a ratio of one or more
//   needs no dividing out, and while the window is still filling the sample passes through.
// Flow: one word at a time; the next word is taken the cycle after the current
//   one has reached the output register.
// Reset: asynchronous, active low; the history memory is not cleared.
`default_nettype none

module kaufman_adaptive_moving_average_core (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire [kama_pkg::CfgIdxBits-1:0]           cfg_index_i,
  input  wire [kama_pkg::CfgDataBits-1:0]          cfg_data_i,
  input  wire                                      in_valid_i,
  output logic                                     in_ready_o,
  input  kama_pkg::sample_t                        sample_re_i,
  input  kama_pkg::sample_t                        sample_im_i,
  input  wire                                      start_of_channel_i,
  output logic                                     out_valid_o,
  input  wire                                      out_ready_i,
  output kama_pkg::sample_t                        out_re_o,
  output kama_pkg::sample_t                        out_im_o
);
  import kama_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_PREP, S_DIV_GO, S_DIV_WAIT, S_MUL_SC, S_SUM,
    S_MUL_W, S_MUL_AVG, S_UPD, S_RES, S_FIN
  } state_e;

  localparam int unsigned ProdBits = QBits + AvgBits + 2;
  localparam int unsigned RndBits  = ProdBits - FracBits;
  localparam int unsigned ErBits   = QBits + QBits + 1;

  function automatic diff_t abs_diff(sample_t a, sample_t b);
    logic signed [SampleBits:0] t;
    t = $signed({a[SampleBits-1], a}) - $signed({b[SampleBits-1], b});
    if (t[SampleBits]) begin
      t = -t;
    end
    return t[DiffBits-1:0];
  endfunction

  // Rounds a Q.32 product to Q.16, ties away from zero.
  function automatic logic signed [RndBits-1:0] round_prod(logic signed [ProdBits-1:0] v);
    logic signed [ProdBits:0] m;
    logic signed [ProdBits:0] t;
    m = v[ProdBits-1] ? -(ProdBits+1)'(v) : (ProdBits+1)'(v);
    t = (m + (ProdBits+1)'(32'sd32768)) >>> FracBits;
    if (v[ProdBits-1]) begin
      t = -t;
    end
    return RndBits'(t);
  endfunction

  function automatic sample_t round_sat(avg_t a);
    logic signed [AvgBits:0] m;
    logic signed [AvgBits:0] t;
    m = a[AvgBits-1] ? -(AvgBits+1)'(a) : (AvgBits+1)'(a);
    t = (m + (AvgBits+1)'(32'sd32768)) >>> FracBits;
    if (a[AvgBits-1]) begin
      t = -t;
    end
    if (t > (AvgBits+1)'((32'sd1 <<< (SampleBits-1)) - 32'sd1)) begin
      t = (AvgBits+1)'((32'sd1 <<< (SampleBits-1)) - 32'sd1);
    end else if (t < -(AvgBits+1)'(32'sd1 <<< (SampleBits-1))) begin
      t = -(AvgBits+1)'(32'sd1 <<< (SampleBits-1));
    end
    return SampleBits'(t);
  endfunction

  state_e                  state_q;
  logic                    comp_q;
  logic [WinRegBits-1:0]   cfg_win_q;
  logic [CfgDataBits-1:0]  cfg_fast_q;
  logic [CfgDataBits-1:0]  cfg_slow_q;

  logic [CountBits-1:0]    fill_q;
  ring_addr_t              head_q;
  logic [CountBits-1:0]    n_q;
  logic [CountBits-1:0]    win_q;
  ring_addr_t              cur_head_q;
  ring_addr_t              back_q;
  sample_t                 x_q [2];
  sample_t                 prev_q [2];
  vol_t                    vol_q [2];
  avg_t                    avg_q [2];
  diff_t                   dir_q [2];
  sample_t                 res_q [2];
  q_t                      er_q;
  logic signed [ErBits-1:0] erp_q;
  q_t                      sc16_q;
  q_t                      w_q;
  logic signed [ProdBits-1:0] prod_q;

  logic                    out_valid_q;
  sample_t                 out_re_q;
  sample_t                 out_im_q;
  logic                    out_load;

  logic [CountBits-1:0]    win_clamped;
  logic                    in_fire;

  ring_word_t              rd_word;
  ring_word_t              wr_word;
  logic                    ram_we;

  sample_t                 old_s [2];
  diff_t                   old_d [2];
  diff_t                   d_new [2];
  vol_t                    v1 [2];
  vol_t                    v2 [2];
  diff_t                   dir_new [2];
  logic                    first;
  logic                    full;

  logic                    div_start;
  logic                    div_done;
  q_t                      div_quot;

  q_t                      fast_c;
  q_t                      slow_c;
  logic signed [QBits:0]   fms;
  logic signed [ErBits+1:0] sc_sum;
  logic [QBits+FracBits-1:0] sc32;
  logic [2*QBits-1:0]      sq;
  logic signed [AvgBits:0] delta;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (cfg_win_q == '0) begin
      win_clamped = CountBits'(1);
    end else if (CountBits'(cfg_win_q) > CountBits'(MaxWindow)) begin
      win_clamped = CountBits'(MaxWindow);
    end else begin
      win_clamped = CountBits'(cfg_win_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_win_q  <= WindowReset;
      cfg_fast_q <= FastReset;
      cfg_slow_q <= SlowReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegWindow: cfg_win_q  <= cfg_data_i[WinRegBits-1:0];
        RegFast:   cfg_fast_q <= cfg_data_i;
        RegSlow:   cfg_slow_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  kama_ring_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (cur_head_q),
    .wr_data_i (wr_word),
    .rd_addr_i (back_q),
    .rd_data_o (rd_word)
  );

  // History update for both components, from the word read at the back of the window.
  always_comb begin
    first    = (n_q == '0);
    full     = (n_q >= win_q);
    old_s[0] = rd_word.smp_re;
    old_s[1] = rd_word.smp_im;
    old_d[0] = rd_word.dif_re;
    old_d[1] = rd_word.dif_im;
    for (int c = 0; c < 2; c++) begin
      d_new[c]   = first ? '0 : abs_diff(x_q[c], prev_q[c]);
      v1[c]      = (first ? '0 : vol_q[c]) + VolBits'(d_new[c]);
      v2[c]      = v1[c];
      if (full) begin
        v2[c] = (v1[c] >= VolBits'(old_d[c])) ? v1[c] - VolBits'(old_d[c]) : '0;
      end
      dir_new[c] = abs_diff(x_q[c], old_s[c]);
    end
    ram_we         = (state_q == S_PREP);
    wr_word.smp_re = x_q[0];
    wr_word.smp_im = x_q[1];
    wr_word.dif_re = d_new[0];
    wr_word.dif_im = d_new[1];
  end

  assign div_start = (state_q == S_DIV_GO);

  kama_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dir_q[comp_q]),
    .divisor_i  (vol_q[comp_q]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    fast_c = (cfg_fast_q > CfgDataBits'(QOne)) ? QOne : QBits'(cfg_fast_q);
    slow_c = (cfg_slow_q > CfgDataBits'(QOne)) ? QOne : QBits'(cfg_slow_q);
    fms    = $signed({1'b0, fast_c}) - $signed({1'b0, slow_c});
    sc_sum = $signed((ErBits+2)'({slow_c, FracBits'(0)})) + (ErBits+2)'(erp_q);
    if (sc_sum[ErBits+1]) begin
      sc32 = '0;
    end else begin
      sc32 = (QBits+FracBits)'(sc_sum);
    end
    sq    = sc16_q * sc16_q;
    delta = $signed({x_q[comp_q][SampleBits-1], x_q[comp_q], FracBits'(0)})
          - (AvgBits+1)'(avg_q[comp_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      comp_q      <= 1'b0;
      fill_q      <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        prev_q[c] <= '0;
        vol_q[c]  <= '0;
        avg_q[c]  <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_PREP;
        end
        S_PREP: begin
          head_q <= cur_head_q + 1'b1;
          fill_q <= (n_q < CountBits'(MaxWindow + 1)) ? n_q + 1'b1 : n_q;
          for (int c = 0; c < 2; c++) begin
            prev_q[c] <= x_q[c];
            vol_q[c]  <= v2[c];
            if (first) begin
              avg_q[c] <= AvgBits'($signed({x_q[c], FracBits'(0)}));
            end
          end
          comp_q  <= 1'b0;
          state_q <= full ? S_DIV_GO : S_FIN;
        end
        S_DIV_GO: begin
          state_q <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state_q <= S_MUL_SC;
          end
        end
        S_MUL_SC:  state_q <= S_SUM;
        S_SUM:     state_q <= S_MUL_W;
        S_MUL_W:   state_q <= S_MUL_AVG;
        S_MUL_AVG: state_q <= S_UPD;
        S_UPD: begin
          avg_q[comp_q] <= avg_q[comp_q] + AvgBits'(round_prod(prod_q));
          state_q       <= S_RES;
        end
        S_RES: begin
          if (comp_q) begin
            state_q <= S_FIN;
          end else begin
            comp_q  <= 1'b1;
            state_q <= S_DIV_GO;
          end
        end
        S_FIN: begin
          if (out_load) begin
            out_re_q    <= res_q[0];
            out_im_q    <= res_q[1];
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q[0]     <= sample_re_i;
      x_q[1]     <= sample_im_i;
      win_q      <= win_clamped;
      n_q        <= start_of_channel_i ? '0 : fill_q;
      cur_head_q <= start_of_channel_i ? '0 : head_q;
      back_q     <= (start_of_channel_i ? '0 : head_q) - RingAw'(win_clamped);
    end
    if (state_q == S_PREP) begin
      dir_q[0] <= dir_new[0];
      dir_q[1] <= dir_new[1];
      res_q[0] <= x_q[0];
      res_q[1] <= x_q[1];
    end
    if (state_q == S_DIV_WAIT && div_done) begin
      er_q <= div_quot;
    end
    if (state_q == S_MUL_SC) begin
      erp_q <= $signed({1'b0, er_q}) * fms;
    end
    if (state_q == S_SUM) begin
      sc16_q <= QBits'((sc32 + (QBits+FracBits)'(32768)) >> FracBits);
    end
    if (state_q == S_MUL_W) begin
      w_q <= QBits'((sq + (2*QBits)'(32768)) >> FracBits);
    end
    if (state_q == S_MUL_AVG) begin
      prod_q <= ProdBits'($signed({1'b0, w_q})) * ProdBits'(delta);
    end
    if (state_q == S_RES) begin
      res_q[comp_q] <= round_sat(avg_q[comp_q]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;

endmodule

`default_nettype wire
